// ===== rtl/psac_pkg.sv =====
// psac_pkg: shared types, constants and step functions for the airspeed converter
// used by every module of the block, no dependencies
`default_nettype none

package psac_pkg;

    localparam int COUNT_W     = 14;
    localparam int FS_W        = 24;
    localparam int PROD_W      = COUNT_W + FS_W;
    localparam int PRES_W      = 24;
    localparam int AIR_W       = 17;
    localparam int STATUS_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int AIR_MUL_W   = 15;
    localparam int AIR_SHIFT   = 6;
    localparam int SCALED_W    = PRES_W + AIR_MUL_W - AIR_SHIFT;
    localparam int RAD_W       = 2 * AIR_W;
    localparam int SQ_REM_W    = AIR_W + 2;
    localparam int REG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_STAGES  = PRES_W;
    localparam int SQRT_STAGES = AIR_W;

    localparam logic [AIR_MUL_W-1:0] AIR_SCALE_MUL = 15'd26749;

    localparam logic [REG_IDX_W-1:0] REG_COUNT_MIN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COUNT_MAX  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MIN_RESET  = 14'd1638;
    localparam logic [COUNT_W-1:0] COUNT_MAX_RESET  = 14'd14745;
    localparam logic [FS_W-1:0]    FULL_SCALE_RESET = 24'd1765059;

    localparam logic [STATUS_W-1:0] STATUS_STALE = 2'b10;

    typedef struct packed {
        logic [COUNT_W-1:0] count_min;
        logic [COUNT_W-1:0] count_max;
        logic [FS_W-1:0]    full_scale;
    } cfg_t;

    // one classified reading between front and back
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  diff;
        logic [COUNT_W-1:0]  span;
    } word_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  rem;
        logic [PRES_W-1:0]   low;
        logic [COUNT_W-1:0]  span;
        logic [STATUS_W-1:0] status;
    } div_stage_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [AIR_W-1:0]    root;
        logic [RAD_W-1:0]    rad;
        logic [PRES_W-1:0]   pressure;
        logic [STATUS_W-1:0] status;
    } sqrt_stage_t;

    // one restoring division step, quotient bit shifts into low
    function automatic div_stage_t div_step(input div_stage_t s);
        logic [COUNT_W:0] trial;
        logic [COUNT_W:0] diff;
        div_stage_t       r;
        r     = s;
        trial = {s.rem, s.low[PRES_W-1]};
        diff  = trial - {1'b0, s.span};
        if (trial >= {1'b0, s.span})
        begin
            r.rem = diff[COUNT_W-1:0];
            r.low = {s.low[PRES_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[COUNT_W-1:0];
            r.low = {s.low[PRES_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one digit of the bitwise square root
    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
        logic [SQ_REM_W+1:0] cat;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W+1:0] diff;
        sqrt_stage_t         r;
        r     = s;
        cat   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        diff  = cat - trial;
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (cat >= trial)
        begin
            r.rem  = diff[SQ_REM_W-1:0];
            r.root = {s.root[AIR_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cat[SQ_REM_W-1:0];
            r.root = {s.root[AIR_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psac_front.sv =====
// psac_front: takes a raw reading, clamps the count and forms offset and span
// depends on psac_pkg
`default_nettype none

module psac_front (
    input  wire logic                          push_in,
    input  wire logic [psac_pkg::BYTE_W-1:0]   raw_high_byte,
    input  wire logic [psac_pkg::BYTE_W-1:0]   raw_low_byte,
    input  wire psac_pkg::cfg_t                cfg,
    output logic                               push,
    output psac_pkg::word_t                    word
);

    logic [psac_pkg::COUNT_W-1:0] count;
    logic [psac_pkg::COUNT_W-1:0] clamped;

    always_comb
    begin
        count       = {raw_high_byte[psac_pkg::COUNT_W-psac_pkg::BYTE_W-1:0], raw_low_byte};
        clamped     = count;
        word.status = raw_high_byte[psac_pkg::BYTE_W-1 -: psac_pkg::STATUS_W];
        if (cfg.count_max > cfg.count_min)
        begin
            if (count < cfg.count_min)
                clamped = cfg.count_min;
            else if (count > cfg.count_max)
                clamped = cfg.count_max;
            word.diff = clamped - cfg.count_min;
            word.span = cfg.count_max - cfg.count_min;
        end
        else
        begin
            // empty range: zero over one gives zero pressure
            word.diff = '0;
            word.span = psac_pkg::COUNT_W'(1);
        end
        push = push_in;
    end

endmodule

`default_nettype wire

// ===== rtl/psac_queue.sv =====
// psac_queue: short word queue between front and back
// depends on psac_pkg
`default_nettype none

module psac_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire psac_pkg::word_t push_word,
    input  wire logic            pop,
    output psac_pkg::word_t      head_word,
    output logic                 empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psac_pkg::word_t  mem [0:DEPTH-1];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        empty      = (count_reg == '0);
        full       = (count_reg == CNT_W'(DEPTH));
        do_push    = push && !full;
        do_pop     = pop && !empty;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        if (do_pop)
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
        head_word = mem[rptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/psac_div.sv =====
// psac_div: scaling multiply and pipelined restoring divide to pressure
// depends on psac_pkg
`default_nettype none

module psac_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire psac_pkg::word_t             in_word,
    input  wire logic [psac_pkg::FS_W-1:0]   full_scale,
    output logic                             out_valid,
    output logic [psac_pkg::PRES_W-1:0]      out_pressure,
    output logic [psac_pkg::STATUS_W-1:0]    out_status
);

    localparam int N = psac_pkg::DIV_STAGES;

    psac_pkg::div_stage_t      stage_reg [0:N];
    logic                      valid_reg [0:N];
    logic [psac_pkg::PROD_W-1:0] product;
    psac_pkg::div_stage_t      first_next;

    always_comb
    begin
        product          = psac_pkg::PROD_W'(in_word.diff) * psac_pkg::PROD_W'(full_scale);
        first_next.rem   = product[psac_pkg::PROD_W-1 -: psac_pkg::COUNT_W];
        first_next.low   = product[psac_pkg::PRES_W-1:0];
        first_next.span  = in_word.span;
        first_next.status = in_word.status;
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            stage_reg[i] <= psac_pkg::div_step(stage_reg[i-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign out_valid    = valid_reg[N];
    assign out_pressure = stage_reg[N].low;
    assign out_status   = stage_reg[N].status;

endmodule

`default_nettype wire

// ===== rtl/psac_sqrt.sv =====
// psac_sqrt: airspeed scaling multiply and pipelined square root, result register
// depends on psac_pkg
`default_nettype none

module psac_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [psac_pkg::PRES_W-1:0] in_pressure,
    input  wire logic [psac_pkg::STATUS_W-1:0] in_status,
    output logic                             out_valid,
    output logic [psac_pkg::PRES_W-1:0]      out_pressure,
    output logic [psac_pkg::AIR_W-1:0]       out_airspeed,
    output logic [psac_pkg::STATUS_W-1:0]    out_status
);

    localparam int N      = psac_pkg::SQRT_STAGES;
    localparam int MULT_W = psac_pkg::PRES_W + psac_pkg::AIR_MUL_W;

    psac_pkg::sqrt_stage_t stage_reg [0:N];
    logic                  valid_reg [0:N];
    logic [MULT_W-1:0]     scaled;
    psac_pkg::sqrt_stage_t first_next;

    always_comb
    begin
        scaled              = MULT_W'(in_pressure) * MULT_W'(psac_pkg::AIR_SCALE_MUL);
        first_next.rem      = '0;
        first_next.root     = '0;
        first_next.rad      = psac_pkg::RAD_W'(scaled[MULT_W-1:psac_pkg::AIR_SHIFT]);
        first_next.pressure = in_pressure;
        first_next.status   = in_status;
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            stage_reg[i] <= psac_pkg::sqrt_step(stage_reg[i-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign out_valid    = valid_reg[N];
    assign out_pressure = stage_reg[N].pressure;
    assign out_airspeed = stage_reg[N].root;
    assign out_status   = stage_reg[N].status;

endmodule

`default_nettype wire

// ===== rtl/pressure_sensor_airspeed_convert.sv =====
// pressure_sensor_airspeed_convert: top level, calibration registers, front, queue, back
// depends on psac_pkg, psac_front, psac_queue, psac_div, psac_sqrt
// path: an accepted word passes the queue register, then the divider and square root stage registers, to done
// throughput: one word per cycle while busy is low; the divider and square root are one bit per stage
// busy stays low for a QUEUE_DEPTH above one since the back drains the queue every cycle and the receiver cannot stall
// reset: async active low, clears all valid bits and queue pointers, loads calibration defaults
`default_nettype none

module pressure_sensor_airspeed_convert #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [psac_pkg::BYTE_W-1:0]      raw_high_byte,
    input  wire logic [psac_pkg::BYTE_W-1:0]      raw_low_byte,
    input  wire logic                             write_enable,
    input  wire logic [psac_pkg::REG_IDX_W-1:0]   reg_index,
    input  wire logic [psac_pkg::CFG_DATA_W-1:0]  write_data,
    output logic                                  done,
    output logic [psac_pkg::PRES_W-1:0]           pressure_q8,
    output logic [psac_pkg::AIR_W-1:0]            airspeed_q8,
    output logic [psac_pkg::STATUS_W-1:0]         sensor_status,
    output logic                                  stale_flag
);

    localparam int LATENCY = 3 + psac_pkg::DIV_STAGES + psac_pkg::SQRT_STAGES;

    psac_pkg::cfg_t  cfg_reg;
    psac_pkg::cfg_t  cfg_next;
    psac_pkg::word_t front_word;
    psac_pkg::word_t head_word;
    logic            front_push;
    logic            q_empty;
    logic            q_full;
    logic            div_valid;
    logic [psac_pkg::PRES_W-1:0]   div_pressure;
    logic [psac_pkg::STATUS_W-1:0] div_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (reg_index)
                psac_pkg::REG_COUNT_MIN:
                    cfg_next.count_min = write_data[psac_pkg::COUNT_W-1:0];
                psac_pkg::REG_COUNT_MAX:
                    cfg_next.count_max = write_data[psac_pkg::COUNT_W-1:0];
                psac_pkg::REG_FULL_SCALE:
                    cfg_next.full_scale = write_data[psac_pkg::FS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_min  <= psac_pkg::COUNT_MIN_RESET;
            cfg_reg.count_max  <= psac_pkg::COUNT_MAX_RESET;
            cfg_reg.full_scale <= psac_pkg::FULL_SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy = q_full;

    psac_front u_front (
        .push_in       (start && !q_full),
        .raw_high_byte (raw_high_byte),
        .raw_low_byte  (raw_low_byte),
        .cfg           (cfg_reg),
        .push          (front_push),
        .word          (front_word)
    );

    psac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_word (front_word),
        .pop       (!q_empty),
        .head_word (head_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    psac_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!q_empty),
        .in_word      (head_word),
        .full_scale   (cfg_reg.full_scale),
        .out_valid    (div_valid),
        .out_pressure (div_pressure),
        .out_status   (div_status)
    );

    psac_sqrt u_sqrt (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .in_pressure  (div_pressure),
        .in_status    (div_status),
        .out_valid    (done),
        .out_pressure (pressure_q8),
        .out_airspeed (airspeed_q8),
        .out_status   (sensor_status)
    );

    assign stale_flag = (sensor_status == psac_pkg::STATUS_STALE);

`ifndef NO_ASSERTIONS
    // every accepted word comes out at done after the queue, divider and square root registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted word did not produce a result on time");

    // back drains one word per cycle so the queue never fills for a QUEUE_DEPTH above one
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled up");

    // zero pressure gives zero airspeed
    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        done && pressure_q8 == '0 |-> airspeed_q8 == '0)
        else $error("nonzero airspeed at zero pressure");

    // clamped offset never exceeds span so pressure stays within full scale
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        done && !$past(write_enable, LATENCY) |-> pressure_q8 <= cfg_reg.full_scale)
        else $error("pressure above full scale");
`endif

endmodule

`default_nettype wire
